@@ rtl/core/median_tds_conductivity_meter_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the conductivity meter core
// Shared concurrent-check forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_TDS_CONDUCTIVITY_METER_CORE_DEFINES_SVH
`define MEDIAN_TDS_CONDUCTIVITY_METER_CORE_DEFINES_SVH

// Same-cycle implication check
`define MTDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication check
`define MTDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/mtds_pkg.sv @@
// ----------------------------------------------------------------------------
// mtds_pkg
// Shared types and constants for the median-filtered TDS/EC meter core.
// ----------------------------------------------------------------------------
package mtds_pkg;

  localparam int MTDS_WINDOW_SIZE = 32;

  // Shared divider geometry
  localparam int DIV_NW = 38;
  localparam int DIV_DW = 19;

  // Voltage scaling: floor(code*mV*8192 / 511875) as a multiply by
  // ceil(2^58 / 511875) and a right shift by 45, exact for 25-bit products
  localparam logic [39:0] VOLT_RCP    = 40'(((64'd1 << 58) / 64'd511875) + 64'd1);
  localparam logic [19:0] VOLT_RCP_HI = VOLT_RCP[39:20];
  localparam logic [19:0] VOLT_RCP_LO = VOLT_RCP[19:0];

  // Fixed-point constants
  localparam logic [18:0] VOLT_MAX     = 19'd524287;
  localparam logic [22:0] EC_MAX       = 23'd8388607;
  localparam logic [13:0] COEF_CUBE    = 14'd13342;
  localparam logic [14:0] COEF_SQUARE  = 15'd25586;
  localparam logic [16:0] COEF_LINEAR  = 17'd85739;

  // Register reset values
  localparam logic [12:0] REF_MV_RESET = 13'd3300;
  localparam logic [9:0]  TEMP_RESET   = 10'd400;
  localparam logic [10:0] TEMP_OFFSET  = 11'd400;

  // Register indexes
  localparam logic REG_REF_MV = 1'b0;
  localparam logic REG_TEMP   = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] numer;
    logic [DIV_DW-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

endpackage

@@ rtl/core/median_tds_conductivity_meter_core.sv @@
// ----------------------------------------------------------------------------
// median_tds_conductivity_meter_core
// Ring window of ADC codes, median by bitwise rank search over the window
// memory, then voltage scaling, cubic EC polynomial and temperature
// compensation, with EC and TDS saturating outputs.
// ----------------------------------------------------------------------------
// Work per input beat: 12 rank passes over the window, the polynomial steps
//   and the EC division. One item at a time, so a new input beat is taken
//   only once the previous result is loaded into the output register.
// A new input beat is taken while the previous result waits at the output.
// Reset (rst, synchronous) clears the window to zero through per-entry valid
//   bits at once, sets write position zero and loads register reset values.
`include "median_tds_conductivity_meter_core_defines.svh"

module median_tds_conductivity_meter_core
  import mtds_pkg::*;
#(
  parameter int WINDOW_SIZE = MTDS_WINDOW_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] adc_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] median_code,
  output logic [18:0] probe_voltage,
  output logic [22:0] conductivity,
  output logic [21:0] dissolved_solids
);

  localparam int  AW   = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int  CW   = $clog2(WINDOW_SIZE + 1);
  localparam bit  EVEN = (WINDOW_SIZE % 2) == 0;
  localparam logic [CW-1:0] K_LO = CW'(EVEN ? WINDOW_SIZE / 2 - 1 : (WINDOW_SIZE - 1) / 2);
  localparam logic [CW-1:0] K_HI = CW'(EVEN ? WINDOW_SIZE / 2 : (WINDOW_SIZE - 1) / 2);
  localparam logic [AW-1:0] LAST_POS = AW'(WINDOW_SIZE - 1);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_SCAN  = 14'b00000000000010,
    S_STEP  = 14'b00000000000100,
    S_MULV  = 14'b00000000001000,
    S_RCP   = 14'b00000000010000,
    S_VOLT  = 14'b00000000100000,
    S_MA    = 14'b00000001000000,
    S_MB    = 14'b00000010000000,
    S_MC    = 14'b00000100000000,
    S_SUM   = 14'b00001000000000,
    S_MD    = 14'b00010000000000,
    S_DIVE  = 14'b00100000000000,
    S_WAITE = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  // Configuration registers
  logic [12:0] reference_millivolts;
  logic [9:0]  water_temperature;

  // Window memory and per-entry valid bits
  logic [11:0]            mem [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0] valid;
  logic [AW-1:0]          wpos;
  logic [11:0]            rd_data;
  logic                   rd_vld;
  logic                   rd_pend;
  logic [CW-1:0]          issue_cnt;

  // Rank search
  logic [3:0]    bit_idx;
  logic [11:0]   r_lo, r_hi;
  logic [CW-1:0] cnt_lo, cnt_hi;
  logic [11:0]   trial_lo, trial_hi;
  logic [11:0]   sample_eff;
  logic [12:0]   mid_sum;
  logic [11:0]   med_c;

  // Arithmetic pipeline registers
  logic [11:0] med;
  logic [24:0] prod_mv;
  logic [44:0] p_hi, p_lo;
  logic [64:0] volt_sum;
  logic [19:0] volt_raw;
  logic [18:0] volt;
  logic [32:0] a1;
  logic [51:0] a2;
  logic [33:0] b1;
  logic [37:0] q16;
  logic [56:0] nv;
  logic [53:0] q32;
  logic [22:0] ec;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_fire;
  logic cfg_wr;
  logic scan_end;

  assign pready   = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite;

  // Register read
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_TEMP) begin
        prdata = {22'b0, water_temperature};
      end else begin
        prdata = {19'b0, reference_millivolts};
      end
    end
  end

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_millivolts <= REF_MV_RESET;
      water_temperature    <= TEMP_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_REF_MV) begin
        reference_millivolts <= pwdata[12:0];
      end else begin
        water_temperature <= pwdata[9:0];
      end
    end
  end

  // Window memory: write on input beat, registered read during the scan
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem[wpos] <= adc_sample;
    end
    rd_data <= mem[issue_cnt[AW-1:0]];
  end

  // Valid bits and write position
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      wpos   <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= valid[issue_cnt[AW-1:0]];
      if (in_fire) begin
        valid[wpos] <= 1'b1;
        wpos        <= (wpos == LAST_POS) ? '0 : wpos + 1'b1;
      end
    end
  end

  assign sample_eff = rd_vld ? rd_data : 12'd0;
  assign trial_lo   = r_lo | (12'd1 << bit_idx);
  assign trial_hi   = r_hi | (12'd1 << bit_idx);
  assign scan_end   = (issue_cnt == CW'(WINDOW_SIZE)) && !rd_pend;
  assign mid_sum    = {1'b0, r_lo} + {1'b0, r_hi};
  assign med_c      = EVEN ? mid_sum[12:1] : r_lo;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_fire) state_next = S_SCAN;
      S_SCAN:  if (scan_end) state_next = S_STEP;
      S_STEP:  state_next = (bit_idx == 4'd0) ? S_MULV : S_SCAN;
      S_MULV:  state_next = S_RCP;
      S_RCP:   state_next = S_VOLT;
      S_VOLT:  state_next = S_MA;
      S_MA:    state_next = S_MB;
      S_MB:    state_next = S_MC;
      S_MC:    state_next = S_SUM;
      S_SUM:   state_next = S_MD;
      S_MD:    state_next = S_DIVE;
      S_DIVE:  state_next = S_WAITE;
      S_WAITE: if (div_rsp.done) state_next = S_DONE;
      S_DONE:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan control: issue one read per entry, count samples below each trial
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      rd_pend   <= 1'b0;
      bit_idx   <= 4'd11;
      cnt_lo    <= '0;
      cnt_hi    <= '0;
      r_lo      <= '0;
      r_hi      <= '0;
    end else begin
      rd_pend <= 1'b0;
      if (in_fire) begin
        issue_cnt <= '0;
        bit_idx   <= 4'd11;
        cnt_lo    <= '0;
        cnt_hi    <= '0;
        r_lo      <= '0;
        r_hi      <= '0;
      end else if (state == S_SCAN) begin
        if (issue_cnt != CW'(WINDOW_SIZE)) begin
          issue_cnt <= issue_cnt + 1'b1;
          rd_pend   <= 1'b1;
        end
        if (rd_pend) begin
          if (sample_eff < trial_lo) cnt_lo <= cnt_lo + 1'b1;
          if (sample_eff < trial_hi) cnt_hi <= cnt_hi + 1'b1;
        end
      end else if (state == S_STEP) begin
        // Keep the trial bit where the rank still fits
        if (cnt_lo <= K_LO) r_lo <= trial_lo;
        if (cnt_hi <= K_HI) r_hi <= trial_hi;
        cnt_lo    <= '0;
        cnt_hi    <= '0;
        issue_cnt <= '0;
        if (bit_idx != 4'd0) bit_idx <= bit_idx - 1'b1;
      end
    end
  end

  // Divider request for the temperature compensation
  always_comb begin
    div_req.start = (state == S_DIVE);
    div_req.numer = DIV_NW'(nv[56:21]);
    div_req.denom = DIV_DW'({1'b0, water_temperature} + TEMP_OFFSET);
  end

  mtds_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Reciprocal product for the voltage scaling
  assign volt_sum = {p_hi, 20'b0} + 65'(p_lo);
  assign volt_raw = volt_sum[64:45];

  // Voltage and polynomial datapath, one registered step per state
  assign q32 = 54'(a2) + (54'(COEF_LINEAR) << 32) - (54'(b1) << 16);

  always_ff @(posedge clk) begin
    unique case (state)
      S_MULV: begin
        med     <= med_c;
        prod_mv <= med_c * reference_millivolts;
      end
      S_RCP: begin
        p_hi <= prod_mv * VOLT_RCP_HI;
        p_lo <= prod_mv * VOLT_RCP_LO;
      end
      S_VOLT:  volt <= (volt_raw > 20'(VOLT_MAX)) ? VOLT_MAX : volt_raw[18:0];
      S_MA:    a1  <= COEF_CUBE * volt;
      S_MB:    a2  <= a1 * volt;
      S_MC:    b1  <= COEF_SQUARE * volt;
      S_SUM:   q16 <= q32[53:16];
      S_MD:    nv  <= q16 * volt;
      S_WAITE: begin
        if (div_rsp.done) begin
          ec <= (div_rsp.quot > DIV_NW'(EC_MAX)) ? EC_MAX : div_rsp.quot[22:0];
        end
      end
      default: ;
    endcase
  end

  // Output register: load when the slot is free, drop on the taken beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      median_code      <= med;
      probe_voltage    <= volt;
      conductivity     <= ec;
      dissolved_solids <= ec[22:1];
    end
  end

  // Checks
  `MTDS_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input taken while busy")
  `MTDS_ASSERT_NOW(a_rank_order, state == S_MULV, r_lo <= r_hi, "median ranks out of order")
  `MTDS_ASSERT_NOW(a_cnt_bound, state == S_STEP, cnt_hi <= CW'(WINDOW_SIZE), "rank count overflow")
  `MTDS_ASSERT_NOW(a_div_idle, div_rsp.done, state == S_WAITE, "divider result with no waiter")

endmodule

@@ rtl/core/mtds_div.sv @@
// ----------------------------------------------------------------------------
// mtds_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtds_div
  import mtds_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] den;
  logic [DIV_NW-1:0] quot;
  logic              done;
  logic [DIV_DW:0]   shifted;
  logic              fits;

  // Shift in the next numerator bit and try the subtract
  assign shifted = {rem, quot[DIV_NW-1]};
  assign fits    = shifted >= {1'b0, den};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      den  <= req.denom;
      quot <= req.numer;
    end else if (busy) begin
      if (fits) begin
        rem <= DIV_DW'(shifted - {1'b0, den});
      end else begin
        rem <= shifted[DIV_DW-1:0];
      end
      quot <= {quot[DIV_NW-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives ADC codes into the conductivity meter core under a range of
// reference and temperature settings. An in-bench median/EC predictor
// computes each result, and the monitor compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import mtds_pkg::*;

  localparam int WIN = MTDS_WINDOW_SIZE;
  localparam logic [2:0] ADDR_REF_MV = {REG_REF_MV, 2'b00};
  localparam logic [2:0] ADDR_TEMP = {REG_TEMP, 2'b00};
  localparam int STALL_LIMIT = 20000;
  localparam longint unsigned VOLT_CAP = 524287;
  localparam longint unsigned EC_CAP = 8388607;
  localparam longint unsigned TDS_CAP = 4194303;

  typedef struct packed {
    logic [11:0] median;
    logic [18:0] volt;
    logic [22:0] ec;
    logic [21:0] tds;
  } meter_reading_t;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [11:0] adc_sample, median_code;
  logic [18:0] probe_voltage;
  logic [22:0] conductivity;
  logic [21:0] dissolved_solids;

  median_tds_conductivity_meter_core u_top (.*);

  // Predictor state and stores
  logic [11:0] code_window [WIN];
  int unsigned wr_pos;
  longint unsigned ref_mv, water_temp;
  logic [11:0] pending_codes[$];
  meter_reading_t expected_readings[$];
  int mismatches, idle_cycles, beats_taken;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Compute the reading that one new code produces
  function automatic meter_reading_t predict_reading(logic [11:0] code);
    logic [11:0] srt [WIN];
    logic [11:0] key;
    longint unsigned med, volt, q32, q16, ec, tds;
    meter_reading_t r;
    int j;
    code_window[wr_pos] = code;
    wr_pos = (wr_pos + 1) % WIN;
    for (int i = 0; i < WIN; i++) srt[i] = code_window[i];
    for (int i = 1; i < WIN; i++) begin
      key = srt[i];
      j = i - 1;
      while (j >= 0 && srt[j] > key) begin
        srt[j + 1] = srt[j];
        j--;
      end
      srt[j + 1] = key;
    end
    if (WIN % 2) med = 64'(srt[(WIN - 1) / 2]);
    else med = (64'(srt[WIN / 2]) + 64'(srt[WIN / 2 - 1])) / 2;
    volt = (med * ref_mv * 65536) / 64'd4095000;
    if (volt > VOLT_CAP) volt = VOLT_CAP;
    q32 = 64'd13342 * volt * volt + (64'd85739 << 32) - 64'd25586 * 64'd65536 * volt;
    q16 = q32 >> 16;
    ec = (q16 * volt * 8) / ((64'd400 + water_temp) << 24);
    tds = ec >> 1;
    if (ec > EC_CAP) ec = EC_CAP;
    if (tds > TDS_CAP) tds = TDS_CAP;
    r.median = med[11:0];
    r.volt = volt[18:0];
    r.ec = ec[22:0];
    r.tds = tds[21:0];
    return r;
  endfunction

  // Driver: present queued codes, idle at random outside the calm stretch
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_readings.push_back(predict_reading(adc_sample));
        beats_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_codes.size() > 0 && (calm || $urandom_range(99) >= 20)) begin
          in_valid <= 1'b1;
          adc_sample <= pending_codes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compare each beat with the oldest reading
  always @(posedge clk) begin
    meter_reading_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 20);
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat median=%0d", median_code);
        end else begin
          exp_r = expected_readings.pop_front();
          if (exp_r.median !== median_code || exp_r.volt !== probe_voltage ||
              exp_r.ec !== conductivity || exp_r.tds !== dissolved_solids) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp med=%0d v=%0d ec=%0d tds=%0d got %0d %0d %0d %0d",
                       exp_r.median, exp_r.volt, exp_r.ec, exp_r.tds, median_code,
                       probe_voltage, conductivity, dissolved_solids);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat on any port
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("median_tds_conductivity_meter_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_REF_MV) ref_mv = 64'(value & 32'h1FFF);
    else if (addr == ADDR_TEMP) water_temp = 64'(value & 32'h3FF);
  endtask

  // Hold until every queued code is sent and every reading is back
  task automatic drain();
    do @(posedge clk);
    while (pending_codes.size() != 0 || in_valid || expected_readings.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  // Queue a run of codes with the given spread: 0 full, 1 high, 2 low, 3 near one value
  task automatic queue_codes(int count, int spread);
    int unsigned centre;
    centre = $urandom_range(4095);
    for (int i = 0; i < count; i++) begin
      case (spread)
        0: pending_codes.push_back(12'($urandom_range(4095)));
        1: pending_codes.push_back(12'($urandom_range(4095, 3900)));
        2: pending_codes.push_back(12'($urandom_range(150)));
        default: pending_codes.push_back(12'((centre + $urandom_range(40)) % 4096));
      endcase
    end
  endtask

  initial begin
    int ref_set [8];
    int temp_set [8];
    ref_set = '{3300, 8191, 0, 5000, 1000, 4096, 2500, 6000};
    temp_set = '{400, 0, 1023, 960, 0, 512, 200, 700};
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    adc_sample = '0;
    calm = 1'b0;
    mismatches = 0;
    beats_taken = 0;
    for (int i = 0; i < WIN; i++) code_window[i] = '0;
    wr_pos = 0;
    ref_mv = 3300;
    water_temp = 400;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes and bit patterns at reset settings
    pending_codes = '{12'd0, 12'd4095, 12'hAAA, 12'h555, 12'd1, 12'd2048, 12'd4094};
    drain();
    // Saturating voltage: a run of top codes at maximum reference
    write_reg(ADDR_REF_MV, 32'd8191);
    write_reg(ADDR_TEMP, 32'd0);
    for (int i = 0; i < 18; i++) pending_codes.push_back(12'd4095);
    drain();

    // Random phases across settings, sender paused at each boundary
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(ADDR_REF_MV, 32'(ref_set[ph]));
      write_reg(ADDR_TEMP, 32'(temp_set[ph]));
      calm = (ph == 3);
      for (int seg = 0; seg < 4; seg++) queue_codes(42, $urandom_range(3));
      drain();
    end
    calm = 1'b0;
    write_reg(ADDR_REF_MV, 32'($urandom_range(8191)));
    write_reg(ADDR_TEMP, 32'($urandom_range(1023)));
    queue_codes(12, 0);
    drain();
    repeat (600) @(posedge clk);

    if (mismatches == 0) begin
      $display("median_tds_conductivity_meter_core verification clean");
    end else begin
      $display("median_tds_conductivity_meter_core verification failed");
    end
    $finish;
  end
endmodule
